@@ rtl/core/mccc_pkg.sv @@
package mccc_pkg;

    localparam int BASE_YEAR        = 2000;
    localparam int TICKS_PER_SECOND = 1000;

    localparam int OP_W     = 2;
    localparam int YEAR_W   = 8;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MILLIS_W = 10;
    localparam int YEARS    = 1 << YEAR_W;

    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_SET  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic [SECOND_W-1:0] SECONDS_PER_MINUTE = SECOND_W'(60);
    localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR   = MINUTE_W'(60);
    localparam logic [HOUR_W-1:0]   HOURS_PER_DAY      = HOUR_W'(24);
    localparam logic [MONTH_W-1:0]  MONTHS_PER_YEAR    = MONTH_W'(12);
    localparam logic [MILLIS_W:0]   TICKS_WRAP         = (MILLIS_W + 1)'(TICKS_PER_SECOND);

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [MILLIS_W-1:0] millis;
    } cal_time_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        cal_time_t       value;
    } cal_item_t;

    function automatic logic [YEARS-1:0] build_leap_mask();
        logic [YEARS-1:0] mask;
        int               y;
        mask = '0;
        for (int i = 0; i < YEARS; i++)
        begin
            y       = BASE_YEAR + i;
            mask[i] = ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
        end
        return mask;
    endfunction

    localparam logic [YEARS-1:0] LEAP_MASK = build_leap_mask();

    function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
        logic [DAY_W-1:0] d;
        unique case (m)
            4'd2:                   d = leap ? DAY_W'(29) : DAY_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11: d = DAY_W'(30);
            default:                d = DAY_W'(31);
        endcase
        return d;
    endfunction

endpackage

@@ rtl/core/mccc_req_if.sv @@
interface mccc_req_if;
    import mccc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [YEAR_W-1:0]   new_year;
    logic [MONTH_W-1:0]  new_month;
    logic [DAY_W-1:0]    new_day;
    logic [HOUR_W-1:0]   new_hour;
    logic [MINUTE_W-1:0] new_minute;
    logic [SECOND_W-1:0] new_second;
    logic [MILLIS_W-1:0] new_millis;

    modport source (
        output valid, op, new_year, new_month, new_day, new_hour, new_minute, new_second,
               new_millis,
        input  ready
    );

    modport sink (
        input  valid, op, new_year, new_month, new_day, new_hour, new_minute, new_second,
               new_millis,
        output ready
    );
endinterface

@@ rtl/core/mccc_rsp_if.sv @@
interface mccc_rsp_if;
    import mccc_pkg::*;

    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year_out;
    logic [MONTH_W-1:0]  month_out;
    logic [DAY_W-1:0]    day_out;
    logic [HOUR_W-1:0]   hour_out;
    logic [MINUTE_W-1:0] minute_out;
    logic [SECOND_W-1:0] second_out;
    logic [MILLIS_W-1:0] millis_out;

    modport source (
        output valid, year_out, month_out, day_out, hour_out, minute_out, second_out,
               millis_out,
        input  ready
    );

    modport sink (
        input  valid, year_out, month_out, day_out, hour_out, minute_out, second_out,
               millis_out,
        output ready
    );
endinterface

@@ rtl/core/mccc_in_stage.sv @@
module mccc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    mccc_req_if.sink            req,
    input  logic                advance,
    output logic                valid,
    output mccc_pkg::cal_item_t item
);
    import mccc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cal_item_t item_reg;
    logic      take;

    assign req.ready  = !valid_reg || advance;
    assign take       = req.valid && req.ready;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op           <= req.op;
            item_reg.value.year   <= req.new_year;
            item_reg.value.month  <= req.new_month;
            item_reg.value.day    <= req.new_day;
            item_reg.value.hour   <= req.new_hour;
            item_reg.value.minute <= req.new_minute;
            item_reg.value.second <= req.new_second;
            item_reg.value.millis <= req.new_millis;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;
endmodule

@@ rtl/core/mccc_calc.sv @@
module mccc_calc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  mccc_pkg::cal_item_t item,
    output mccc_pkg::cal_time_t now
);
    import mccc_pkg::*;

    cal_time_t          time_reg;
    cal_time_t          time_next;
    cal_time_t          carried;
    logic [MILLIS_W:0]  ms_inc;
    logic               sec_carry;
    logic [DAY_W-1:0]   dim;

    assign ms_inc    = {1'b0, time_reg.millis} + (MILLIS_W + 1)'(1);
    assign sec_carry = (ms_inc >= TICKS_WRAP);
    assign dim       = month_days(time_reg.month, LEAP_MASK[time_reg.year]);

    // second carry: each fold checked in turn
    always_comb
    begin
        carried        = time_reg;
        carried.second = time_reg.second + SECOND_W'(1);
        if (carried.second >= SECONDS_PER_MINUTE)
        begin
            carried.second = '0;
            carried.minute = carried.minute + MINUTE_W'(1);
        end
        if (carried.minute >= MINUTES_PER_HOUR)
        begin
            carried.minute = '0;
            carried.hour   = carried.hour + HOUR_W'(1);
        end
        if (carried.hour >= HOURS_PER_DAY)
        begin
            carried.hour = '0;
            carried.day  = carried.day + DAY_W'(1);
        end
        if (carried.day > dim)
        begin
            carried.day   = DAY_W'(1);
            carried.month = carried.month + MONTH_W'(1);
        end
        if (carried.month > MONTHS_PER_YEAR)
        begin
            carried.month = MONTH_W'(1);
            carried.year  = carried.year + YEAR_W'(1);
        end
    end

    always_comb
    begin
        time_next = time_reg;
        priority if (item.op == OP_TICK)
        begin
            if (sec_carry)
            begin
                time_next        = carried;
                time_next.millis = MILLIS_W'(ms_inc - TICKS_WRAP);
            end
            else
            begin
                time_next.millis = ms_inc[MILLIS_W-1:0];
            end
        end
        else if (item.op == OP_SET)
        begin
            time_next = item.value;
        end
        else
        begin
            time_next = time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg.year   <= '0;
            time_reg.month  <= MONTH_W'(1);
            time_reg.day    <= DAY_W'(1);
            time_reg.hour   <= '0;
            time_reg.minute <= '0;
            time_reg.second <= '0;
            time_reg.millis <= '0;
        end
        else if (advance)
        begin
            time_reg <= time_next;
        end
    end

    assign now = time_next;
endmodule

@@ rtl/core/mccc_out_stage.sv @@
module mccc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  mccc_pkg::cal_time_t value,
    output logic                free,
    mccc_rsp_if.source          rsp
);
    import mccc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cal_time_t value_reg;

    assign free       = !valid_reg || rsp.ready;
    assign valid_next = load || (valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value;
        end
    end

    assign rsp.valid      = valid_reg;
    assign rsp.year_out   = value_reg.year;
    assign rsp.month_out  = value_reg.month;
    assign rsp.day_out    = value_reg.day;
    assign rsp.hour_out   = value_reg.hour;
    assign rsp.minute_out = value_reg.minute;
    assign rsp.second_out = value_reg.second;
    assign rsp.millis_out = value_reg.millis;
endmodule

@@ rtl/core/millisecond_calendar_clock_top.sv @@
// Channel | Dir | Word
// req     | in  | op, new_year, new_month, new_day, new_hour, new_minute, new_second, new_millis
// rsp     | out | year_out, month_out, day_out, hour_out, minute_out, second_out, millis_out
//
// One word per cycle in each direction while rsp is not stalled.
// A taken word waits in the input register; the result register takes its carried result.
// Reset (rst_n low) sets 1 January of the base year, 00:00:00.000 and empties both registers.
// A stalled rsp holds its word; req keeps being taken while the input register can move on.
module millisecond_calendar_clock_top (
    input  logic       clk,
    input  logic       rst_n,
    mccc_req_if.sink   req,
    mccc_rsp_if.source rsp
);
    import mccc_pkg::*;

    logic      s1_valid;
    cal_item_t s1_item;
    cal_time_t now;
    logic      out_free;
    logic      advance;

    assign advance = s1_valid && out_free;

    mccc_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (advance),
        .valid   (s1_valid),
        .item    (s1_item)
    );

    mccc_calc u_calc (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item),
        .now     (now)
    );

    mccc_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance),
        .value (now),
        .free  (out_free),
        .rsp   (rsp)
    );

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("input taken while both registers are full and stalled");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(s1_valid))
        else $error("result appeared without a word in the input register");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(u_calc.time_reg))
        else $error("calendar state changed without an item");
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import mccc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_WORDS = 1080;
    localparam int PRINT_LIMIT  = 20;

    logic clk;
    logic rst_n;

    mccc_req_if req ();
    mccc_rsp_if rsp ();

    millisecond_calendar_clock_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [YEAR_W-1:0]   cal_year;
    logic [MONTH_W-1:0]  cal_month;
    logic [DAY_W-1:0]    cal_day;
    logic [HOUR_W-1:0]   cal_hour;
    logic [MINUTE_W-1:0] cal_minute;
    logic [SECOND_W-1:0] cal_second;
    logic [MILLIS_W:0]   cal_millis;

    cal_time_t expected_times[$];

    int errors       = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int tick_count   = 0;
    int set_count    = 0;
    int read_count   = 0;
    int carry_count  = 0;
    int wrap_count   = 0;
    int cycle_count  = 0;

    bit src_steady = 1'b0;
    bit snk_steady = 1'b0;
    bit hold_rsp   = 1'b0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [DAY_W-1:0] month_length(logic [MONTH_W-1:0] m,
                                                       logic [YEAR_W-1:0] y);
        int  full_year;
        bit  leap;
        full_year = BASE_YEAR + int'(y);
        leap      = (full_year % 4 == 0) && ((full_year % 100 != 0) || (full_year % 400 == 0));
        case (m)
            4'd2:                    return leap ? DAY_W'(29) : DAY_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11: return DAY_W'(30);
            default:                 return DAY_W'(31);
        endcase
    endfunction

    function automatic void roll_second();
        carry_count++;
        cal_second = cal_second + SECOND_W'(1);
        if (cal_second >= SECONDS_PER_MINUTE)
        begin
            cal_second = '0;
            cal_minute = cal_minute + MINUTE_W'(1);
        end
        if (cal_minute >= MINUTES_PER_HOUR)
        begin
            cal_minute = '0;
            cal_hour   = cal_hour + HOUR_W'(1);
        end
        if (cal_hour >= HOURS_PER_DAY)
        begin
            cal_hour = '0;
            cal_day  = cal_day + DAY_W'(1);
        end
        if (cal_day > month_length(cal_month, cal_year))
        begin
            cal_day   = DAY_W'(1);
            cal_month = cal_month + MONTH_W'(1);
        end
        if (cal_month > MONTHS_PER_YEAR)
        begin
            cal_month = MONTH_W'(1);
            cal_year  = cal_year + YEAR_W'(1);
            if (cal_year == '0)
                wrap_count++;
        end
    endfunction

    function automatic cal_time_t apply_word(logic [OP_W-1:0] op, cal_time_t w);
        logic [MILLIS_W:0] next_ms;
        cal_time_t         now;
        if (op == OP_TICK)
        begin
            tick_count++;
            next_ms = cal_millis + (MILLIS_W + 1)'(1);
            if (next_ms >= TICKS_WRAP)
            begin
                next_ms = next_ms - TICKS_WRAP;
                roll_second();
            end
            cal_millis = next_ms;
        end
        else if (op == OP_SET)
        begin
            set_count++;
            cal_year   = w.year;
            cal_month  = w.month;
            cal_day    = w.day;
            cal_hour   = w.hour;
            cal_minute = w.minute;
            cal_second = w.second;
            cal_millis = {1'b0, w.millis};
        end
        else
        begin
            read_count++;
        end
        now.year   = cal_year;
        now.month  = cal_month;
        now.day    = cal_day;
        now.hour   = cal_hour;
        now.minute = cal_minute;
        now.second = cal_second;
        now.millis = cal_millis[MILLIS_W-1:0];
        return now;
    endfunction

    function automatic cal_time_t make_time(int y, int mo, int d, int h, int mi, int s, int ms);
        cal_time_t t;
        t.year   = YEAR_W'(y);
        t.month  = MONTH_W'(mo);
        t.day    = DAY_W'(d);
        t.hour   = HOUR_W'(h);
        t.minute = MINUTE_W'(mi);
        t.second = SECOND_W'(s);
        t.millis = MILLIS_W'(ms);
        return t;
    endfunction

    function automatic cal_time_t noise_time();
        logic [63:0] raw;
        cal_time_t   t;
        raw = {$urandom(), $urandom()};
        t   = raw[$bits(cal_time_t)-1:0];
        return t;
    endfunction

    // Bias toward the last millisecond, second, minute, hour and day.
    function automatic cal_time_t boundary_time();
        cal_time_t        t;
        logic [DAY_W-1:0] len;
        t.year  = YEAR_W'($urandom_range(0, 255));
        t.month = MONTH_W'($urandom_range(1, 12));
        len     = month_length(t.month, t.year);
        case ($urandom_range(0, 2))
            0:       t.day = len;
            1:       t.day = DAY_W'($urandom_range(1, int'(len)));
            default: t.day = DAY_W'($urandom_range(1, 31));
        endcase
        t.hour   = $urandom_range(0, 1) ? HOUR_W'(23) : HOUR_W'($urandom_range(0, 23));
        t.minute = $urandom_range(0, 1) ? MINUTE_W'(59) : MINUTE_W'($urandom_range(0, 59));
        t.second = $urandom_range(0, 1) ? SECOND_W'(59) : SECOND_W'($urandom_range(0, 59));
        t.millis = ($urandom_range(0, 3) == 0) ? MILLIS_W'($urandom_range(0, 999))
                                               : MILLIS_W'($urandom_range(992, 999));
        return t;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        case ($urandom_range(0, 11))
            0:       return OP_READ;
            1:       return OP_UNUSED;
            2:       return OP_SET;
            default: return OP_TICK;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        if (errors < PRINT_LIMIT)
            $display("[%0t] mismatch: %0s", $realtime, msg);
        errors++;
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %0s got %0d want %0d",
                                      results_seen, name, got, want));
    endtask

    task automatic check_result();
        cal_time_t want;
        if (expected_times.size() == 0)
        begin
            report_mismatch("result word with no pending time");
            return;
        end
        want = expected_times.pop_front();
        compare_field("year",   16'(rsp.year_out),   16'(want.year));
        compare_field("month",  16'(rsp.month_out),  16'(want.month));
        compare_field("day",    16'(rsp.day_out),    16'(want.day));
        compare_field("hour",   16'(rsp.hour_out),   16'(want.hour));
        compare_field("minute", 16'(rsp.minute_out), 16'(want.minute));
        compare_field("second", 16'(rsp.second_out), 16'(want.second));
        compare_field("millis", 16'(rsp.millis_out), 16'(want.millis));
        results_seen++;
    endtask

    task automatic send_word(logic [OP_W-1:0] op, cal_time_t w);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.op         <= op;
        req.new_year   <= w.year;
        req.new_month  <= w.month;
        req.new_day    <= w.day;
        req.new_hour   <= w.hour;
        req.new_minute <= w.minute;
        req.new_second <= w.second;
        req.new_millis <= w.millis;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        expected_times.push_back(apply_word(op, w));
        words_sent++;
    endtask

    task automatic set_then_tick(cal_time_t w);
        send_word(OP_SET, w);
        send_word(OP_TICK, noise_time());
    endtask

    task automatic test_reset_and_reads();
        send_word(OP_READ, noise_time());
        send_word(OP_UNUSED, noise_time());
    endtask

    task automatic test_second_carry();
        set_then_tick(make_time(0, 1, 1, 0, 0, 0, 999));
    endtask

    task automatic test_year_wrap();
        set_then_tick(make_time(255, 12, 31, 23, 59, 59, 999));
    endtask

    task automatic test_february();
        set_then_tick(make_time(0, 2, 28, 23, 59, 59, 999));
        set_then_tick(make_time(0, 2, 29, 23, 59, 59, 999));
        set_then_tick(make_time(100, 2, 28, 23, 59, 59, 999));
    endtask

    task automatic test_out_of_range_set();
        logic [63:0] ones;
        ones = '1;
        set_then_tick(ones[$bits(cal_time_t)-1:0]);
        set_then_tick(make_time(10, 4, 31, 23, 59, 59, 999));
        set_then_tick(make_time(10, 0, 31, 23, 59, 59, 999));
        set_then_tick(make_time(10, 13, 5, 6, 7, 59, 999));
        set_then_tick(make_time(10, 6, 0, 8, 9, 10, 999));
        set_then_tick(make_time(10, 6, 15, 8, 8, 8, 1023));
    endtask

    task automatic test_random_calendar(int n_words);
        int start;
        int burst;
        start = words_sent;
        while (words_sent - start < n_words)
        begin
            if ($urandom_range(0, 7) == 0)
                src_steady = ~src_steady;
            if ($urandom_range(0, 7) == 0)
                snk_steady = ~snk_steady;
            if ($urandom_range(0, 4) == 0)
                send_word(OP_SET, noise_time());
            else
                send_word(OP_SET, boundary_time());
            burst = $urandom_range(1, 10);
            repeat (burst)
                send_word(pick_op(), noise_time());
        end
        src_steady = 1'b0;
        snk_steady = 1'b0;
    endtask

    task automatic test_stalled_results();
        hold_rsp   = 1'b1;
        src_steady = 1'b1;
        send_word(OP_SET, make_time(7, 3, 31, 23, 59, 59, 995));
        repeat (40)
            send_word(OP_TICK, noise_time());
        src_steady = 1'b0;
    endtask

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int gap;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_rsp)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else
            begin
                gap = snk_steady ? 0 : $urandom_range(0, 6);
                if (gap > 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp.valid !== 1'b1);
            check_result();
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.op         <= OP_TICK;
        req.new_year   <= '0;
        req.new_month  <= '0;
        req.new_day    <= '0;
        req.new_hour   <= '0;
        req.new_minute <= '0;
        req.new_second <= '0;
        req.new_millis <= '0;
        cal_year   = '0;
        cal_month  = MONTH_W'(1);
        cal_day    = DAY_W'(1);
        cal_hour   = '0;
        cal_minute = '0;
        cal_second = '0;
        cal_millis = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_and_reads();
        test_second_carry();
        test_year_wrap();
        test_february();
        test_out_of_range_set();
        test_random_calendar(RANDOM_WORDS / 2);
        test_stalled_results();
        test_random_calendar(RANDOM_WORDS / 2);

        req.valid <= 1'b0;
        while (expected_times.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d words (%0d ticks, %0d sets, %0d reads), checked %0d results.",
                 words_sent, tick_count, set_count, read_count, results_seen);
        $display("Clock carried %0d seconds and wrapped the year %0d times; %0d mismatches.",
                 carry_count, wrap_count, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/mccc_pkg.sv
rtl/core/mccc_req_if.sv
rtl/core/mccc_rsp_if.sv
rtl/core/mccc_in_stage.sv
rtl/core/mccc_calc.sv
rtl/core/mccc_out_stage.sv
rtl/core/millisecond_calendar_clock_top.sv
verif/tb.sv
